[src/assert_macros.svh]
// Assertion macros used by the receiver RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with active-low reset disable
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must hold at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/sfr_pkg.sv]
// Types and constants for the serial frame receiver
`default_nettype none

package sfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned TickW  = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ByteW-1:0] HeadFirstRst  = 8'd170;
  localparam logic [ByteW-1:0] HeadSecondRst = 8'd85;
  localparam logic [ByteW-1:0] TailFirstRst  = 8'd85;
  localparam logic [ByteW-1:0] TailSecondRst = 8'd170;
  localparam logic [TickW-1:0] TimeoutRst    = 16'd2000;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgHeadFirst  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgHeadSecond = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgTailFirst  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTailSecond = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTimeout    = 3'd4;

  typedef enum logic [3:0] {
    PH_HEAD1 = 4'd0,
    PH_HEAD2 = 4'd1,
    PH_CMD   = 4'd2,
    PH_LEN   = 4'd3,
    PH_DATA  = 4'd4,
    PH_CS2   = 4'd5,
    PH_TAIL1 = 4'd6,
    PH_TAIL2 = 4'd7
  } phase_t;

  typedef enum logic [3:0] {
    K_HEAD1 = 4'd0,
    K_HEAD2 = 4'd1,
    K_CMD   = 4'd2,
    K_LEN   = 4'd3,
    K_DATA  = 4'd4,
    K_CS1   = 4'd5,
    K_CS2   = 4'd6,
    K_TAIL1 = 4'd7,
    K_TAIL2 = 4'd8
  } kind_t;

endpackage

`default_nettype wire

[src/serial_frame_receiver.sv]
// Serial frame receiver: header/length/tail frame parser over a byte and tick stream
// Each input word is either a received byte (in_mode 0) or one timer tick (in_mode 1),
// and it yields exactly one result word. A word is taken every cycle: the parse state
// updates in the cycle of acceptance and the result sits in the output register from
// the next cycle, so throughput is one word per clock, held
// back only when the output register is full and not being taken. Frames are head1,
// head2, command, length, length data bytes, two checksum bytes (not checked), tail1,
// tail2; mismatching header-2 or tail bytes are skipped. Ticks count from head1 and
// drop an unfinished frame at the programmed timeout (0 behaves as 1).
`default_nettype none
`include "assert_macros.svh"

module serial_frame_receiver import sfr_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // configuration
  input  wire logic                cfg_wr_en,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata,
  // input words
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic                in_mode,
  input  wire logic [ByteW-1:0]    in_byte_in,
  // result words
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      logic                out_byte_taken,
  output      logic [ByteW-1:0]    out_byte_out,
  output      logic [3:0]          out_field_kind,
  output      logic [ByteW-1:0]    out_data_index,
  output      logic                out_frame_done,
  output      logic                out_timed_out
);

  logic [ByteW-1:0] head_first_r, head_second_r, tail_first_r, tail_second_r;
  logic [TickW-1:0] timeout_r;

  phase_t           phase_r, phase_nxt;
  logic [ByteW-1:0] len_r, len_nxt;
  logic [ByteW-1:0] cnt_r, cnt_nxt;
  logic [TickW-1:0] tick_r, tick_nxt;
  logic             run_r, run_nxt;

  logic             taken_nxt, done_nxt, tout_nxt;
  kind_t            kind_nxt;
  logic [ByteW-1:0] bout_nxt, idx_nxt;
  logic [TickW-1:0] limit, tick_inc;

  logic             out_valid_r;
  logic             taken_r, done_r, tout_r;
  kind_t            kind_r;
  logic [ByteW-1:0] bout_r, idx_r;

  logic accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_first_r  <= HeadFirstRst;
      head_second_r <= HeadSecondRst;
      tail_first_r  <= TailFirstRst;
      tail_second_r <= TailSecondRst;
      timeout_r     <= TimeoutRst;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CfgHeadFirst:  head_first_r  <= cfg_wdata[ByteW-1:0];
        CfgHeadSecond: head_second_r <= cfg_wdata[ByteW-1:0];
        CfgTailFirst:  tail_first_r  <= cfg_wdata[ByteW-1:0];
        CfgTailSecond: tail_second_r <= cfg_wdata[ByteW-1:0];
        CfgTimeout:    timeout_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign limit    = (timeout_r == '0) ? TickW'(1) : timeout_r;
  assign tick_inc = tick_r + TickW'(1);

  // next state and result
  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    tick_nxt  = tick_r;
    run_nxt   = run_r;
    taken_nxt = 1'b0;
    bout_nxt  = '0;
    kind_nxt  = K_HEAD1;
    idx_nxt   = '0;
    done_nxt  = 1'b0;
    tout_nxt  = 1'b0;

    if (in_mode) begin
      if (run_r) begin
        tick_nxt = tick_inc;
        if (tick_inc >= limit) begin
          tick_nxt  = '0;
          run_nxt   = 1'b0;
          phase_nxt = PH_HEAD1;
          tout_nxt  = 1'b1;
        end
      end
    end else begin
      unique case (phase_r)
        PH_HEAD2: begin
          if (in_byte_in == head_second_r) begin
            taken_nxt = 1'b1;
            kind_nxt  = K_HEAD2;
            phase_nxt = PH_CMD;
          end
        end
        PH_CMD: begin
          taken_nxt = 1'b1;
          kind_nxt  = K_CMD;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          taken_nxt = 1'b1;
          kind_nxt  = K_LEN;
          len_nxt   = in_byte_in;
          cnt_nxt   = '0;
          phase_nxt = PH_DATA;
        end
        PH_DATA: begin
          taken_nxt = 1'b1;
          if (cnt_r >= len_r) begin
            kind_nxt  = K_CS1;
            phase_nxt = PH_CS2;
          end else begin
            kind_nxt = K_DATA;
            idx_nxt  = cnt_r;
            cnt_nxt  = cnt_r + ByteW'(1);
          end
        end
        PH_CS2: begin
          taken_nxt = 1'b1;
          kind_nxt  = K_CS2;
          phase_nxt = PH_TAIL1;
        end
        PH_TAIL1: begin
          if (in_byte_in == tail_first_r) begin
            taken_nxt = 1'b1;
            kind_nxt  = K_TAIL1;
            phase_nxt = PH_TAIL2;
          end
        end
        PH_TAIL2: begin
          if (in_byte_in == tail_second_r) begin
            taken_nxt = 1'b1;
            kind_nxt  = K_TAIL2;
            done_nxt  = 1'b1;
            run_nxt   = 1'b0;
            tick_nxt  = '0;
            phase_nxt = PH_HEAD1;
          end
        end
        default: begin
          phase_nxt = PH_HEAD1;
          if (in_byte_in == head_first_r) begin
            taken_nxt = 1'b1;
            kind_nxt  = K_HEAD1;
            tick_nxt  = '0;
            run_nxt   = 1'b1;
            phase_nxt = PH_HEAD2;
          end
        end
      endcase
      if (taken_nxt) begin
        bout_nxt = in_byte_in;
      end
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD1;
      len_r   <= '0;
      cnt_r   <= '0;
      tick_r  <= '0;
      run_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      tick_r  <= tick_nxt;
      run_r   <= run_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      taken_r <= taken_nxt;
      bout_r  <= bout_nxt;
      kind_r  <= kind_nxt;
      idx_r   <= idx_nxt;
      done_r  <= done_nxt;
      tout_r  <= tout_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte_taken = taken_r;
  assign out_byte_out   = bout_r;
  assign out_field_kind = kind_r;
  assign out_data_index = idx_r;
  assign out_frame_done = done_r;
  assign out_timed_out  = tout_r;

  // timer runs exactly while a frame is open
  `ASSERT_CLK(a_run_phase, clk, rst_n, run_r == (phase_r != PH_HEAD1), "timer and phase disagree")
  // a stopped timer holds a cleared count
  `ASSERT_CLK(a_idle_tick, clk, rst_n, !run_r |-> tick_r == '0, "stopped timer not cleared")
  // completion only on an accepted second tail byte
  `ASSERT_CLK(a_done_kind, clk, rst_n,
    out_valid_r && done_r |-> taken_r && kind_r == K_TAIL2 && !tout_r,
    "frame done without tail2")
  // tick on a stopped timer produces an empty result
  `ASSERT_CLK(a_idle_tick_out, clk, rst_n,
    accept && in_mode && !run_r |=> out_valid_r && !taken_r && !tout_r && !done_r,
    "idle tick produced a non-empty result")

endmodule

`default_nettype wire
